// File: rtl/vsa_pkg.sv
// Shared types and constants for the sound voice allocator.
// Depends on nothing; vsa_gain, the top level and the checker refer to it by scoped names.
package vsa_pkg;

  // Action codes carried in the request beat.
  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  localparam logic [15:0] HANDLE_BASE = 16'd100;
  localparam logic [8:0]  PAN_SPAN    = 9'd257;

  // Request beat, first field in the most significant bits.
  typedef struct packed {
    logic        action;
    logic [7:0]  sound_id;
    logic        exclusive;
    logic [6:0]  volume;
    logic [7:0]  separation;
    logic [17:0] pitch_step;
    logic [31:0] sample_address;
    logic [23:0] sample_length;
    logic [30:0] current_tick;
    logic [2:0]  release_voice;
  } vsa_in_t;

  // Response beat.
  typedef struct packed {
    logic        accepted;
    logic [2:0]  voice;
    logic [15:0] handle;
    logic [6:0]  left_gain;
    logic [6:0]  right_gain;
    logic        evicted_valid;
    logic [7:0]  evicted_id;
  } vsa_out_t;

  // Status of the pan gain unit.
  typedef struct packed {
    logic       done;
    logic [6:0] left;
    logic [6:0] right;
  } vsa_gain_t;

endpackage

// File: rtl/vsa_ram.sv
// Synchronous single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module vsa_ram #(
  parameter int DW = 39,
  parameter int AW = 3
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [(1 << AW)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/vsa_store.sv
// Per-voice playback record: sample address, length, step and packed gains.
// Depends on nothing; the mixer side that reads it lies outside this block.
module vsa_store #(
  parameter int AW = 3
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   address,
  input  logic [23:0]   length,
  input  logic [17:0]   step,
  input  logic [13:0]   gains
);

  logic [87:0] mem [(1 << AW)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {address, length, step, gains};
    end
  end

endmodule

// File: rtl/vsa_gain.sv
// Pan gain unit: left and right gains from a quadratic pan law, one shared
// multiplier used four times. Depends on vsa_pkg.
module vsa_gain (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [6:0]        volume,
  input  logic [7:0]        separation,
  output vsa_pkg::vsa_gain_t res
);

  logic        run;
  logic [1:0]  ph;
  logic [6:0]  vol_q;
  logic [8:0]  dist_l;
  logic [8:0]  dist_r;
  logic [14:0] part;
  logic [14:0] mul_a;
  logic [8:0]  mul_b;
  logic [23:0] prod;
  logic [7:0]  cut;
  logic [6:0]  gain;

  // Even phases form vol*d, odd phases square it up: vol*d*d.
  assign dist_r = vsa_pkg::PAN_SPAN - dist_l;
  assign mul_a  = ph[0] ? part : {8'd0, vol_q};
  assign mul_b  = ph[1] ? dist_r : dist_l;
  assign prod   = 24'(mul_a) * 24'(mul_b);
  assign cut    = prod[23:16];
  // Gain clamps at zero once the cut reaches vol; vol never exceeds 127, so the result fits seven bits.
  assign gain   = (cut >= {1'b0, vol_q}) ? 7'd0 : vol_q - cut[6:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run      <= 1'b0;
      ph       <= 2'd0;
      res.done <= 1'b0;
    end else if (go) begin
      run      <= 1'b1;
      ph       <= 2'd0;
      res.done <= 1'b0;
      vol_q    <= volume;
      dist_l   <= {1'b0, separation} + 9'd1;
    end else if (run) begin
      ph <= ph + 2'd1;
      if (!ph[0]) begin
        part <= prod[14:0];
      end else if (!ph[1]) begin
        res.left <= gain;
      end else begin
        res.right <= gain;
        run       <= 1'b0;
        res.done  <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/sound_voice_allocator_top.sv
// Sound voice allocator: assigns playback voices with oldest-voice stealing.
// Depends on vsa_pkg, vsa_ram, vsa_store and vsa_gain.
//
// Usage:
//   Request channel (req_valid / req_stall / req): one beat per action,
//   either start a sound or release a voice whose sample ended. The block
//   works on one request at a time and raises req_stall while busy.
//   Response channel (rsp_valid / rsp_stall / rsp): exactly one beat per
//   request, in order. A finished response sits in the output register
//   while the next request is already taken in.
//   Configuration: cfg_wr_en writes cfg_wr_data into the enable bit; write
//   it only while the block is idle. With the enable clear, starts are
//   refused (all-zero response) and releases still work.
// Sequence: a start reads each voice in turn from the voice memory, whose
//   read is registered, then the commit state writes the chosen voice back
//   and loads the response once the output register is free.
//   The gain unit runs its four multiplies alongside the scan. Releases and
//   refused starts answer from the finish state once the output is free.
// Reset: synchronous, clears the enable, all busy flags, the handle counter
//   and the response valid flag. The voice memories need no clearing pass.
// Stall: while rsp_stall holds a response, the next result waits in its
//   final state and no further request is taken.
module sound_voice_allocator_top #(
  parameter int VOICES = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              req_valid,
  output logic              req_stall,
  input  vsa_pkg::vsa_in_t  req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output vsa_pkg::vsa_out_t rsp
);

  localparam int AW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CW = $clog2(VOICES + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_COMMIT, S_FINISH} state_t;

  state_t              state;
  logic                enabled;
  logic [VOICES-1:0]   active;
  vsa_pkg::vsa_in_t    item;
  logic [15:0]         handle_counter;

  // Scan bookkeeping.
  logic [CW-1:0]       iss;
  logic                rd_pend;
  logic [AW-1:0]       rd_idx;
  logic                found;
  logic [AW-1:0]       found_idx;
  logic [30:0]         oldest;
  logic [AW-1:0]       oldest_idx;
  logic [7:0]          oldest_snd;

  logic                accept;
  logic                out_free;
  logic                issue;
  logic                gain_go;
  logic [38:0]         rdata;
  logic [7:0]          rd_snd;
  logic [30:0]         rd_start;
  logic                match;
  vsa_pkg::vsa_gain_t  gain;

  logic [VOICES-1:0]   act_left;
  logic                all_busy;
  logic [AW-1:0]       free_idx;
  logic [AW-1:0]       slot;
  logic                commit;
  logic [15:0]         handle_cur;
  logic                rel_ok;
  logic                rel_hit;
  logic                rsp_load;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign gain_go   = accept && (req.action == vsa_pkg::ACT_START) && enabled;

  // Voice memory: {sound id, start tick} per voice.
  assign issue    = (state == S_SCAN) && (iss < CW'(VOICES));
  assign rd_snd   = rdata[38:31];
  assign rd_start = rdata[30:0];
  assign match    = item.exclusive && !found && active[rd_idx] && (rd_snd == item.sound_id);

  // Voices still busy once an exclusive match is freed.
  always_comb begin
    act_left = active;
    for (int i = 0; i < VOICES; i++) begin
      if (found && (found_idx == AW'(i))) begin
        act_left[i] = 1'b0;
      end
    end
  end

  // Lowest free voice.
  always_comb begin
    free_idx = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!act_left[i]) begin
        free_idx = AW'(i);
      end
    end
  end

  assign all_busy   = &act_left;
  assign slot       = all_busy ? oldest_idx : free_idx;
  assign commit     = (state == S_COMMIT) && out_free;
  assign handle_cur = (handle_counter == 16'd0) ? vsa_pkg::HANDLE_BASE : handle_counter;
  assign rel_ok     = 32'(item.release_voice) < VOICES;
  assign rel_hit    = (item.action == vsa_pkg::ACT_RELEASE) && rel_ok;
  assign rsp_load   = out_free && ((state == S_COMMIT) || (state == S_FINISH));

  vsa_ram #(.DW(39), .AW(AW)) u_voice_ram (
    .clk   (clk),
    .we    (commit),
    .waddr (slot),
    .wdata ({item.sound_id, item.current_tick}),
    .raddr (iss[AW-1:0]),
    .rdata (rdata)
  );

  vsa_store #(.AW(AW)) u_store (
    .clk     (clk),
    .we      (commit),
    .waddr   (slot),
    .address (item.sample_address),
    .length  (item.sample_length),
    .step    (item.pitch_step),
    .gains   ({gain.left, gain.right})
  );

  vsa_gain u_gain (
    .clk        (clk),
    .rst        (rst),
    .go         (gain_go),
    .volume     (req.volume),
    .separation (req.separation),
    .res        (gain)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      enabled        <= 1'b0;
      active         <= '0;
      handle_counter <= 16'd0;
      rd_pend        <= 1'b0;
      rsp_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        enabled <= cfg_wr_data;
      end
      // Load a new beat, or drop the response once the receiver takes it.
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            item    <= req;
            iss     <= '0;
            rd_pend <= 1'b0;
            found   <= 1'b0;
            oldest  <= req.current_tick;
            state   <= gain_go ? S_SCAN : S_FINISH;
          end
        end

        S_SCAN: begin
          // Issue one voice read a cycle; evaluate each entry in the cycle after its read is issued.
          if (issue) begin
            iss <= iss + CW'(1);
          end
          rd_pend <= issue;
          rd_idx  <= iss[AW-1:0];
          if (rd_pend) begin
            if (match) begin
              found     <= 1'b1;
              found_idx <= rd_idx;
            end
            if (rd_idx == '0) begin
              // Voice 0 is the fallback when no start tick is strictly older.
              oldest_idx <= '0;
              oldest_snd <= rd_snd;
              if (rd_start < oldest) begin
                oldest <= rd_start;
              end
            end else if (rd_start < oldest) begin
              oldest     <= rd_start;
              oldest_idx <= rd_idx;
              oldest_snd <= rd_snd;
            end
          end
          if (!issue && !rd_pend && gain.done) begin
            state <= S_COMMIT;
          end
        end

        S_COMMIT: begin
          if (out_free) begin
            active         <= act_left | (VOICES'(1) << slot);
            handle_counter <= handle_cur + 16'd1;
            rsp.accepted      <= 1'b1;
            rsp.voice         <= 3'(slot);
            rsp.handle        <= handle_cur;
            rsp.left_gain     <= gain.left;
            rsp.right_gain    <= gain.right;
            rsp.evicted_valid <= all_busy;
            rsp.evicted_id    <= all_busy ? oldest_snd : 8'd0;
            state          <= S_IDLE;
          end
        end

        S_FINISH: begin
          // Release or refused start.
          if (out_free) begin
            rsp.accepted      <= rel_hit;
            rsp.voice         <= rel_hit ? item.release_voice : 3'd0;
            rsp.handle        <= 16'd0;
            rsp.left_gain     <= 7'd0;
            rsp.right_gain    <= 7'd0;
            rsp.evicted_valid <= 1'b0;
            rsp.evicted_id    <= 8'd0;
            for (int i = 0; i < VOICES; i++) begin
              if (rel_hit && (32'(item.release_voice) == i)) begin
                active[i] <= 1'b0;
              end
            end
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/vsa_checker.sv
// Port-level checks for the sound voice allocator, bound to the top level.
// Depends on vsa_pkg and sound_voice_allocator_top.
module vsa_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_stall,
  input logic              rsp_valid,
  input logic              rsp_stall,
  input vsa_pkg::vsa_out_t rsp
);

  // A held response keeps its beat.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // One request at a time: after an accept the block stalls.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second request taken while busy");

  // Reset empties the response register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  // Refused or out-of-range beats carry no handle, gain or eviction.
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.accepted |-> rsp.handle == 16'd0 && !rsp.evicted_valid
      && rsp.left_gain == 7'd0 && rsp.right_gain == 7'd0)
    else $error("refused response not zero");

  // No eviction, no evicted id.
  a_evict_id: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.evicted_valid |-> rsp.evicted_id == 8'd0)
    else $error("evicted id without eviction");

endmodule

bind sound_voice_allocator_top vsa_checker u_vsa_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
